// ===== rtl/core/lwsm_pkg.sv =====
package lwsm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int PAT_BYTES       = 32;
  localparam int PAT_IDX_W       = 5;
  localparam int LEN_W           = 6;
  localparam int LINE_W          = 24;
  localparam int COL_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int WORD_BYTES      = 8;
  localparam int OUT_DATA_W      = 40;

  localparam logic [7:0] LF_BYTE         = 8'h0A;
  localparam logic [7:0] UNDERSCORE_BYTE = 8'h5F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_WORD0  = 3'd0,
    REG_PAT_WORD1  = 3'd1,
    REG_PAT_WORD2  = 3'd2,
    REG_PAT_WORD3  = 3'd3,
    REG_PAT_LENGTH = 3'd4,
    REG_MATCH_CASE = 3'd5,
    REG_WHOLE_WORD = 3'd6
  } cfg_reg_t;

  // per-cell compare setup, recomputed from the registers every cycle
  typedef struct packed {
    logic [7:0] target;
    logic       care;
    logic       left;
  } cell_ctrl_t;

  typedef struct packed {
    logic             match_case;
    logic             whole_word;
    logic             enable;
    logic [LEN_W-1:0] need;
  } match_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic match_case);
    if (!match_case && b >= 8'h61 && b <= 8'h7A) begin
      return b - 8'h20;
    end
    return b;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == UNDERSCORE_BYTE);
  endfunction

endpackage

// ===== rtl/core/line_word_string_matcher_core.sv =====
// Byte-stream substring matcher. One text byte is taken per cycle unless the
// master side stalls; the byte that completes a report (plain mode) or follows
// it (whole-word mode) goes into the cell row, then the report is registered.
// The text sits in a row of PATTERN_MAX+2 byte cells that shift on every
// transfer; every cell compares its byte against its pattern byte in
// parallel, so the whole pattern is checked in the cycle after the byte
// arrives. A register write takes effect for bytes accepted from the next
// cycle on. Reports give 1-based line and column of the first matched byte,
// both saturating. cfg_ready is always high.
module line_word_string_matcher_core #(
  parameter int PATTERN_MAX = lwsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,    // [7:0] text_byte
  input  logic                                s_tuser,    // [0] first_of_file
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lwsm_pkg::OUT_DATA_W-1:0]     m_tdata,    // [23:0] line_number, [39:24] column_number
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lwsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lwsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = PATTERN_MAX + 2;
  localparam int LW    = lwsm_pkg::LEN_W;
  localparam int LNW   = lwsm_pkg::LINE_W;
  localparam int CW    = lwsm_pkg::COL_W;

  lwsm_pkg::cell_ctrl_t  cell_ctrl [DEPTH];
  lwsm_pkg::match_ctrl_t mctrl;

  logic [7:0] chain [DEPTH+1];
  logic [DEPTH-1:0] ok_vec;
  logic [DEPTH-1:0] lbad_vec;

  // running per-line state
  logic [LW-1:0]  line_fill;
  logic [CW-1:0]  column_count;
  logic [LNW-1:0] line_count;

  // step under compare
  logic           s_valid;
  logic [LW-1:0]  s_fill;
  logic [CW-1:0]  s_col;
  logic [LNW-1:0] s_line;

  logic           accept;
  logic           advance;
  logic           found;
  logic [LW-1:0]  base_fill;
  logic [CW-1:0]  base_col;
  logic [LNW-1:0] base_line;
  logic [LW-1:0]  fill_next;
  logic [CW-1:0]  col_next;
  logic [CW-1:0]  report_col;

  assign cfg_ready = 1'b1;

  lwsm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .cell_ctrl (cell_ctrl),
    .mctrl     (mctrl)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s_valid || advance;
  assign accept   = s_tvalid && s_tready;

  assign chain[0] = s_tdata;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lwsm_cell u_cell (
      .clk        (clk),
      .shift_en   (accept),
      .data_in    (chain[i]),
      .data_out   (chain[i+1]),
      .ctrl       (cell_ctrl[i]),
      .match_case (mctrl.match_case),
      .in_line    (s_fill > LW'(i)),
      .ok         (ok_vec[i]),
      .left_bad   (lbad_vec[i])
    );
  end

  // first_of_file restarts counting; stale history is masked by the fill count
  assign base_fill = s_tuser ? '0 : line_fill;
  assign base_col  = s_tuser ? '0 : column_count;
  assign base_line = s_tuser ? LNW'(1) : line_count;
  assign fill_next = (base_fill < LW'(DEPTH)) ? base_fill + LW'(1) : base_fill;
  assign col_next  = (base_col != '1) ? base_col + CW'(1) : base_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill    <= '0;
      column_count <= '0;
      line_count   <= LNW'(1);
      s_valid      <= 1'b0;
    end else begin
      if (accept) begin
        s_valid <= 1'b1;
        if (s_tdata == lwsm_pkg::LF_BYTE) begin
          line_fill    <= '0;
          column_count <= '0;
          line_count   <= (base_line != '1) ? base_line + LNW'(1) : base_line;
        end else begin
          line_fill    <= fill_next;
          column_count <= col_next;
          line_count   <= base_line;
        end
      end else if (advance) begin
        s_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_fill <= fill_next;
      s_col  <= col_next;
      s_line <= base_line;
    end
  end

  // chain[1] is the newest byte, i.e. the byte after a whole-word match
  assign found = s_valid && mctrl.enable && (s_fill >= mctrl.need) && (&ok_vec) &&
                 (!mctrl.whole_word ||
                  (!lwsm_pkg::is_word_byte(chain[1]) && !(|lbad_vec)));

  assign report_col = (s_col == '1) ? s_col : s_col - CW'(mctrl.need) + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && found) begin
      m_tdata <= {report_col, s_line};
    end
  end

endmodule

// ===== rtl/core/lwsm_cell.sv =====
module lwsm_cell (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic [7:0]            data_in,
  output logic [7:0]            data_out,
  input  lwsm_pkg::cell_ctrl_t  ctrl,
  input  logic                  match_case,
  input  logic                  in_line,
  output logic                  ok,
  output logic                  left_bad
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= data_in;
    end
  end

  assign data_out = held;

  assign ok = !ctrl.care ||
              (lwsm_pkg::fold_byte(held, match_case) == ctrl.target);

  // byte just before a whole-word match, only counts inside the current line
  assign left_bad = ctrl.left && in_line && lwsm_pkg::is_word_byte(held);

endmodule

// ===== rtl/core/lwsm_cfg.sv =====
module lwsm_cfg #(
  parameter int PATTERN_MAX = lwsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [lwsm_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [lwsm_pkg::CFG_DATA_W-1:0]     wr_data,
  output lwsm_pkg::cell_ctrl_t                cell_ctrl [PATTERN_MAX+2],
  output lwsm_pkg::match_ctrl_t               mctrl
);

  localparam int DEPTH = PATTERN_MAX + 2;
  localparam int LW    = lwsm_pkg::LEN_W;

  logic [7:0]    pat [lwsm_pkg::PAT_BYTES];
  logic [LW-1:0] pattern_length;
  logic          match_case;
  logic          whole_word;

  logic [LW-1:0]         len_c;
  lwsm_pkg::cell_ctrl_t  cell_ctrl_next [DEPTH];
  lwsm_pkg::match_ctrl_t mctrl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < lwsm_pkg::PAT_BYTES; k++) begin
        pat[k] <= '0;
      end
      pattern_length <= LW'(1);
      match_case     <= 1'b0;
      whole_word     <= 1'b0;
    end else if (wr_en) begin
      case (lwsm_pkg::cfg_reg_t'(wr_index))
        lwsm_pkg::REG_PAT_WORD0, lwsm_pkg::REG_PAT_WORD1,
        lwsm_pkg::REG_PAT_WORD2, lwsm_pkg::REG_PAT_WORD3: begin
          for (int b = 0; b < lwsm_pkg::WORD_BYTES; b++) begin
            pat[{wr_index[1:0], 3'(b)}] <= wr_data[8*b +: 8];
          end
        end
        lwsm_pkg::REG_PAT_LENGTH: pattern_length <= wr_data[LW-1:0];
        lwsm_pkg::REG_MATCH_CASE: match_case     <= wr_data[0];
        lwsm_pkg::REG_WHOLE_WORD: whole_word     <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign len_c = (pattern_length > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : pattern_length;

  // cell i compares against pattern byte len-1-i (plain) or len-i (whole word)
  always_comb begin
    logic [LW:0] kk;
    kk = '0;
    for (int i = 0; i < DEPTH; i++) begin
      kk = {1'b0, len_c} - (LW+1)'(i) - {{LW{1'b0}}, !whole_word};
      cell_ctrl_next[i].target = lwsm_pkg::fold_byte(pat[kk[lwsm_pkg::PAT_IDX_W-1:0]],
                                                     match_case);
      cell_ctrl_next[i].care   = whole_word ? (i >= 1 && i <= int'(len_c))
                                            : (i < int'(len_c));
      cell_ctrl_next[i].left   = whole_word && (i == int'(len_c) + 1);
    end
    mctrl_next.match_case = match_case;
    mctrl_next.whole_word = whole_word;
    mctrl_next.enable     = (len_c != '0);
    mctrl_next.need       = len_c + LW'(whole_word);
  end

  always_ff @(posedge clk) begin
    cell_ctrl <= cell_ctrl_next;
    mctrl     <= mctrl_next;
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import lwsm_pkg::*;

  localparam int HIST_DEPTH  = PATTERN_MAX_DEF + 2;
  localparam int LINE_SAT    = 16777215;
  localparam int COL_SAT     = 65535;
  localparam int QUIET_LIMIT = 5000;

  // Tracks line, column and the recent bytes of the text and queues the
  // match reports that the matcher must produce.
  class match_tracker;
    logic [CFG_DATA_W-1:0] pat_word [4];
    logic [LEN_W-1:0]      pat_len;
    logic                  exact_case;
    logic                  word_mode;
    logic [7:0]            recent [HIST_DEPTH];
    int unsigned           line_fill;
    int unsigned           line_no;
    int unsigned           col_no;
    logic [OUT_DATA_W-1:0] expected_hits [$];
    int unsigned           mismatches;

    function new();
      foreach (pat_word[i]) pat_word[i] = '0;
      pat_len    = 1;
      exact_case = 1'b0;
      word_mode  = 1'b0;
      mismatches = 0;
      clear_file();
    endfunction

    function void clear_file();
      foreach (recent[i]) recent[i] = 8'h00;
      line_fill = 0;
      line_no   = 1;
      col_no    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PAT_WORD0:  pat_word[0] = value;
        REG_PAT_WORD1:  pat_word[1] = value;
        REG_PAT_WORD2:  pat_word[2] = value;
        REG_PAT_WORD3:  pat_word[3] = value;
        REG_PAT_LENGTH: pat_len = value[LEN_W-1:0];
        REG_MATCH_CASE: exact_case = value[0];
        REG_WHOLE_WORD: word_mode = value[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] upcase(logic [7:0] b);
      if (!exact_case && b >= 8'h61 && b <= 8'h7A) begin
        return b - 8'h20;
      end
      return b;
    endfunction

    function bit ident_char(logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A) || (b == UNDERSCORE_BYTE);
    endfunction

    // pattern byte k sits at recent[off+len-1-k]
    function bit pattern_ends_at(int unsigned off, int unsigned len);
      int unsigned k;
      int unsigned pos;
      for (k = 0; k < len; k++) begin
        pos = off + len - 1 - k;
        if (pos >= HIST_DEPTH) begin
          return 1'b0;
        end
        if (upcase(recent[pos]) != upcase(pat_word[k / 8][(k % 8) * 8 +: 8])) begin
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_text(logic [7:0] b, logic first);
      int unsigned len;
      int unsigned col;
      int          i;
      bit          hit;
      if (first) begin
        clear_file();
      end
      for (i = HIST_DEPTH - 1; i > 0; i--) begin
        recent[i] = recent[i - 1];
      end
      recent[0] = b;
      if (line_fill < HIST_DEPTH) line_fill++;
      if (col_no < COL_SAT) col_no++;
      len = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len;
      hit = 1'b0;
      col = 0;
      if (len > 0) begin
        if (!word_mode) begin
          if (line_fill >= len && pattern_ends_at(0, len)) begin
            hit = 1'b1;
            col = (col_no >= COL_SAT) ? COL_SAT : col_no - len + 1;
          end
        end else if (line_fill >= len + 1 && !ident_char(b) && pattern_ends_at(1, len)) begin
          // left neighbor only counts when it is still in this line
          if (!(line_fill >= len + 2 && ident_char(recent[len + 1]))) begin
            hit = 1'b1;
            col = (col_no >= COL_SAT) ? COL_SAT : col_no - len;
          end
        end
      end
      if (hit) begin
        expected_hits.push_back({col[COL_W-1:0], line_no[LINE_W-1:0]});
      end
      if (b == LF_BYTE) begin
        line_fill = 0;
        col_no    = 0;
        if (line_no < LINE_SAT) line_no++;
      end
    endfunction

    function void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s", what);
      end
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      if (expected_hits.size() == 0) begin
        flag_mismatch($sformatf("unexpected report line %0d column %0d",
                                got[LINE_W-1:0], got[OUT_DATA_W-1:LINE_W]));
      end else begin
        want = expected_hits.pop_front();
        if (got[LINE_W-1:0] !== want[LINE_W-1:0]) begin
          flag_mismatch($sformatf("line_number expected %0d, got %0d",
                                  want[LINE_W-1:0], got[LINE_W-1:0]));
        end
        if (got[OUT_DATA_W-1:LINE_W] !== want[OUT_DATA_W-1:LINE_W]) begin
          flag_mismatch($sformatf("column_number expected %0d, got %0d",
                                  want[OUT_DATA_W-1:LINE_W], got[OUT_DATA_W-1:LINE_W]));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  match_tracker tracker = new();

  int unsigned sender_idle_pct = 12;
  int unsigned sink_idle_pct   = 12;
  int unsigned hold_request    = 0;
  int unsigned bytes_sent      = 0;
  int unsigned quiet_cycles    = 0;
  logic [7:0]  pat_bytes [32];
  int unsigned pat_use;

  always #1 clk = ~clk;

  line_word_string_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // report sink: random backpressure plus the occasional long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        tracker.check_report(m_tdata);
      end
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_text(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_text(b, first);
    bytes_sent++;
  endtask

  task automatic send_string(input string s, input logic first);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_text(s[i], (i == 0) ? first : 1'b0);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_word(int w);
    logic [CFG_DATA_W-1:0] word;
    int k;
    for (k = 0; k < WORD_BYTES; k++) begin
      word[k * 8 +: 8] = pat_bytes[w * WORD_BYTES + k];
    end
    return word;
  endfunction

  task automatic load_pattern(input logic [LEN_W-1:0] len, input bit exact, input bit words);
    write_reg(REG_PAT_WORD0, pack_word(0));
    write_reg(REG_PAT_WORD1, pack_word(1));
    write_reg(REG_PAT_WORD2, pack_word(2));
    write_reg(REG_PAT_WORD3, pack_word(3));
    write_reg(REG_PAT_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_MATCH_CASE, CFG_DATA_W'(exact));
    write_reg(REG_WHOLE_WORD, CFG_DATA_W'(words));
    cfg_valid <= 1'b0;
    pat_use = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
  endtask

  // sender pauses until every queued report has come back, then settles
  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_from(input string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return ((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h7A);
  endfunction

  task automatic send_boundary();
    case ($urandom_range(2))
      0: send_text(pick_from(" .,-\t"), 1'b0);
      1: send_text(pick_from("aZ_7"), 1'b0);
      default: ;
    endcase
  endtask

  // mostly pattern occurrences with random case, boundaries and damage
  task automatic run_text(input int unsigned n);
    int unsigned target;
    int unsigned r;
    int unsigned k;
    logic [7:0]  b;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 40 && pat_use > 0) begin
        send_boundary();
        for (k = 0; k < pat_use; k++) begin
          b = pat_bytes[k];
          if (is_letter(b) && $urandom_range(3) == 0) b = b ^ 8'h20;
          if ($urandom_range(24) == 0) b = 8'($urandom_range(255));
          send_text(b, 1'b0);
        end
        send_boundary();
      end else if (r < 50) begin
        send_text(LF_BYTE, 1'b0);
      end else if (r < 53) begin
        send_text(8'($urandom_range(255)), 1'b1);
      end else if (r < 65) begin
        send_text(8'($urandom_range(255)), 1'b0);
      end else begin
        send_text(pick_from("abcAB_19 .\t"), 1'b0);
      end
    end
  endtask

  initial begin
    int ph;
    int k;
    logic [LEN_W-1:0] len;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset setup: one-byte pattern of zero, so NUL bytes in the text match
    send_text(8'h00, 1'b1);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(LF_BYTE, 1'b0);
    send_text(8'h00, 1'b0);
    wait_for_reports();

    // overlapping hits with case folding
    foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
    pat_bytes[0] = "a";
    pat_bytes[1] = "b";
    pat_bytes[2] = "a";
    load_pattern(3, 1'b0, 1'b0);
    send_string("xAbAba\nab", 1'b0);
    wait_for_reports();

    // whole words with exact case: punctuation, underscore, high byte, line feed
    load_pattern(3, 1'b1, 1'b1);
    send_string(" aba,aba_aba", 1'b1);
    send_text(8'h80, 1'b0);
    send_string("aba\nABA ", 1'b0);
    wait_for_reports();

    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0: len = LEN_W'(32);
        1: len = LEN_W'(0);
        2: len = LEN_W'(63);
        3: len = LEN_W'(40);
        default: len = LEN_W'(($urandom_range(4) == 0) ? $urandom_range(7, 31)
                                                       : $urandom_range(1, 6));
      endcase
      for (k = 0; k < 32; k++) begin
        if (ph == 5) pat_bytes[k] = 8'hFF;
        else if (k < len) pat_bytes[k] = pick_from("abcAB_19.");
        else pat_bytes[k] = 8'($urandom_range(255));
      end
      if (ph == 4) pat_bytes[$urandom_range(len - 1)] = LF_BYTE;
      sender_idle_pct = (ph == 6) ? 0 : 12;
      sink_idle_pct   = (ph == 6) ? 0 : 12;
      load_pattern(len, 1'($urandom_range(1)), 1'(ph % 2));
      run_text(75);
      wait_for_reports();
    end

    // long sink hold-off while every byte matches: the block fills and stalls
    pat_bytes[0] = "a";
    load_pattern(1, 1'b0, 1'b0);
    hold_request = 300;
    for (k = 0; k < 120; k++) begin
      send_text($urandom_range(1) ? "a" : "A", 1'b0);
    end
    wait_for_reports();

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
